FILE: src/cei_pkg.sv
package cei_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;

    localparam int VID_W  = 10;
    localparam int VC_W   = 11;
    localparam int SLOT_W = 13;
    localparam int EDGE_W = 14;
    localparam int ST_W   = 3;
    localparam int OP_W   = 2;
    localparam int SA_W   = $clog2(MAX_EDGES);
    localparam int RA_W   = $clog2(MAX_VERTICES + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [ST_W-1:0] STS_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] STS_PRESENT  = 3'd1;
    localparam logic [ST_W-1:0] STS_DELETED  = 3'd2;
    localparam logic [ST_W-1:0] STS_ABSENT   = 3'd3;
    localparam logic [ST_W-1:0] STS_RANGE    = 3'd4;
    localparam logic [ST_W-1:0] STS_FULL     = 3'd5;
    localparam logic [ST_W-1:0] STS_READ     = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HI,
        ST_BOUNDS,
        ST_RD_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_OFF_RD,
        ST_OFF_WR,
        ST_RESP
    } t_state;

endpackage

FILE: src/cei_if.sv
interface cei_in_if;
    import cei_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [VID_W-1:0]  source_vertex;
    logic [VID_W-1:0]  target_vertex;
    logic [SLOT_W-1:0] neighbor_slot;
    modport source (output valid, op, source_vertex, target_vertex, neighbor_slot,
                    input ready);
    modport sink   (input valid, op, source_vertex, target_vertex, neighbor_slot,
                    output ready);
endinterface

interface cei_out_if;
    import cei_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [EDGE_W-1:0] degree;
    logic [VID_W-1:0]  neighbor_value;
    logic [EDGE_W-1:0] edge_total;
    modport source (output valid, status, degree, neighbor_value, edge_total,
                    input ready);
    modport sink   (input valid, status, degree, neighbor_value, edge_total,
                    output ready);
endinterface

FILE: src/cei_ram.sv
module cei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/csr_edge_insert_delete.sv
// Channel   Dir  Payload                                        Transfer
// i_item    in   op, source_vertex, target_vertex, neighbor_slot valid & ready
// o_result  out  status, degree, neighbor_value, edge_total     valid & ready
// i_cfg_*   in   vertex_count (11 bits)                         i_cfg_we high
//
// One item at a time. An out-of-range item goes straight to the response.
// A read fetches both offsets, then the store entry at the slot; a slot beyond
// the degree skips the store read. Insert/delete scan the list entry by entry;
// a change then moves store entries, each read, then written, writes the new
// target (insert), and updates each offset entry from source+1 to 1024, each
// entry being read, then written. Reset starts a clearing pass of the offsets;
// ready is high only when idle, and one result may wait in the output register meanwhile.
module csr_edge_insert_delete (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [cei_pkg::VC_W-1:0] i_cfg_wdata,
    cei_in_if.sink                   i_item,
    cei_out_if.source                o_result
);
    import cei_pkg::*;

    t_state r_state, n_state;

    logic [VC_W-1:0]   r_vertex_count;
    logic [EDGE_W-1:0] r_stored;
    logic [OP_W-1:0]   r_op;
    logic [VID_W-1:0]  r_src, r_dst;
    logic [SLOT_W-1:0] r_slot;
    logic [EDGE_W-1:0] r_lo, r_hi, r_pos;
    logic              r_found;
    logic [RA_W-1:0]   r_vaddr;
    logic [ST_W-1:0]   r_status;
    logic [EDGE_W-1:0] r_degree;
    logic [VID_W-1:0]  r_value;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [EDGE_W-1:0] r_out_degree;
    logic [VID_W-1:0]  r_out_value;
    logic [EDGE_W-1:0] r_out_total;

    // RAM ports
    logic              st_we;
    logic [SA_W-1:0]   st_waddr, st_raddr;
    logic [VID_W-1:0]  st_wdata, st_rdata;
    logic              rs_we;
    logic [RA_W-1:0]   rs_waddr, rs_raddr;
    logic [EDGE_W-1:0] rs_wdata, rs_rdata;

    cei_ram #(.WIDTH(VID_W), .DEPTH(MAX_EDGES)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    cei_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_VERTICES + 1)) u_row_start (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (rs_wdata),
        .i_raddr (rs_raddr),
        .o_rdata (rs_rdata)
    );

    logic [VC_W-1:0]   active_n;
    logic              accept, out_free, in_range;
    logic [EDGE_W-1:0] hi_c, lo_c, span_c;
    logic              last_vaddr;

    assign active_n = (r_vertex_count > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES)
                                                             : r_vertex_count;
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign in_range = (i_item.op != OP_UNUSED)
                   && ({1'b0, i_item.source_vertex} < active_n)
                   && ((i_item.op == OP_READ)
                       || ({1'b0, i_item.target_vertex} < active_n));

    // clamp the list bounds to the filled part of the store
    assign hi_c   = (rs_rdata > r_stored) ? r_stored : rs_rdata;
    assign lo_c   = (r_lo > hi_c) ? hi_c : r_lo;
    assign span_c = hi_c - lo_c;
    assign last_vaddr = (r_vaddr == RA_W'(MAX_VERTICES));

    assign i_item.ready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (last_vaddr) n_state = ST_IDLE;
            ST_IDLE:     if (accept) n_state = in_range ? ST_HI : ST_RESP;
            ST_HI:       n_state = ST_BOUNDS;
            ST_BOUNDS: begin
                if (r_op == OP_READ) begin
                    n_state = ({1'b0, r_slot} < span_c) ? ST_RD_WAIT : ST_RESP;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_RD_WAIT:  n_state = ST_RESP;
            ST_SCAN_RD:  n_state = (r_pos < r_hi) ? ST_SCAN_CMP : ST_DECIDE;
            ST_SCAN_CMP: n_state = (st_rdata == r_dst) ? ST_DECIDE : ST_SCAN_RD;
            ST_DECIDE: begin
                if (r_op == OP_INSERT) begin
                    if (r_found || r_stored >= EDGE_W'(MAX_EDGES)) n_state = ST_RESP;
                    else n_state = ST_SH_RD;
                end else begin
                    n_state = r_found ? ST_SH_RD : ST_RESP;
                end
            end
            ST_SH_RD: begin
                if (r_op == OP_INSERT) begin
                    n_state = (r_pos > r_hi) ? ST_SH_WR : ST_PUT;
                end else begin
                    n_state = (r_pos < r_stored) ? ST_SH_WR : ST_OFF_RD;
                end
            end
            ST_SH_WR:    n_state = ST_SH_RD;
            ST_PUT:      n_state = ST_OFF_RD;
            ST_OFF_RD:   n_state = ST_OFF_WR;
            ST_OFF_WR:   n_state = last_vaddr ? ST_RESP : ST_OFF_RD;
            ST_RESP:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = st_rdata;
        st_raddr = '0;
        rs_we    = 1'b0;
        rs_waddr = r_vaddr;
        rs_wdata = '0;
        rs_raddr = '0;
        case (r_state)
            ST_CLEAR: begin
                rs_we = 1'b1;
            end
            ST_IDLE: begin
                rs_raddr = RA_W'(i_item.source_vertex);
            end
            ST_HI: begin
                rs_raddr = RA_W'(r_src) + RA_W'(1);
            end
            ST_BOUNDS: begin
                st_raddr = SA_W'(lo_c + EDGE_W'(r_slot));
            end
            ST_SCAN_RD: begin
                st_raddr = r_pos[SA_W-1:0];
            end
            ST_SH_RD: begin
                if (r_op == OP_INSERT) st_raddr = SA_W'(r_pos - EDGE_W'(1));
                else st_raddr = r_pos[SA_W-1:0];
            end
            ST_SH_WR: begin
                st_we = 1'b1;
                if (r_op == OP_INSERT) st_waddr = r_pos[SA_W-1:0];
                else st_waddr = SA_W'(r_pos - EDGE_W'(1));
            end
            ST_PUT: begin
                st_we    = 1'b1;
                st_waddr = r_hi[SA_W-1:0];
                st_wdata = r_dst;
            end
            ST_OFF_RD: begin
                rs_raddr = r_vaddr;
            end
            ST_OFF_WR: begin
                rs_we    = 1'b1;
                rs_wdata = (r_op == OP_INSERT) ? rs_rdata + EDGE_W'(1)
                                               : rs_rdata - EDGE_W'(1);
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_vertex_count <= VC_W'(MAX_VERTICES);
            r_stored       <= '0;
            r_vaddr        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vertex_count <= i_cfg_wdata;
            if (r_state == ST_CLEAR) r_vaddr <= r_vaddr + RA_W'(1);
            if (r_state == ST_DECIDE) r_vaddr <= RA_W'(r_src) + RA_W'(1);
            if (r_state == ST_OFF_WR && !last_vaddr) r_vaddr <= r_vaddr + RA_W'(1);
            if (r_state == ST_PUT) r_stored <= r_stored + EDGE_W'(1);
            if (r_state == ST_SH_RD && r_op == OP_DELETE && r_pos >= r_stored) begin
                r_stored <= r_stored - EDGE_W'(1);
            end
            if (r_state == ST_RESP && out_free) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op     <= i_item.op;
                r_src    <= i_item.source_vertex;
                r_dst    <= i_item.target_vertex;
                r_slot   <= i_item.neighbor_slot;
                r_found  <= 1'b0;
                r_status <= STS_RANGE;
                r_degree <= '0;
                r_value  <= '0;
            end
            ST_HI: begin
                r_lo <= rs_rdata;
            end
            ST_BOUNDS: begin
                r_lo     <= lo_c;
                r_hi     <= hi_c;
                r_pos    <= lo_c;
                r_degree <= span_c;
                if (r_op == OP_READ) r_status <= STS_READ;
            end
            ST_RD_WAIT: begin
                r_value <= st_rdata;
            end
            ST_SCAN_CMP: begin
                if (st_rdata == r_dst) r_found <= 1'b1;
                else r_pos <= r_pos + EDGE_W'(1);
            end
            ST_DECIDE: begin
                if (r_op == OP_INSERT) begin
                    r_pos <= r_stored;
                    if (r_found) r_status <= STS_PRESENT;
                    else if (r_stored >= EDGE_W'(MAX_EDGES)) r_status <= STS_FULL;
                    else begin
                        r_status <= STS_INSERTED;
                        r_degree <= r_degree + EDGE_W'(1);
                    end
                end else begin
                    r_pos <= r_pos + EDGE_W'(1);
                    if (r_found) begin
                        r_status <= STS_DELETED;
                        r_degree <= r_degree - EDGE_W'(1);
                    end else begin
                        r_status <= STS_ABSENT;
                    end
                end
            end
            ST_SH_WR: begin
                if (r_op == OP_INSERT) r_pos <= r_pos - EDGE_W'(1);
                else r_pos <= r_pos + EDGE_W'(1);
            end
            ST_RESP: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_degree <= r_degree;
                    r_out_value  <= r_value;
                    r_out_total  <= r_stored;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_status;
    assign o_result.degree         = r_out_degree;
    assign o_result.neighbor_value = r_out_value;
    assign o_result.edge_total     = r_out_total;

`ifndef SYNTHESIS
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= EDGE_W'(MAX_EDGES))
        else $error("edge count above store depth");
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_state == ST_SH_WR || r_state == ST_PUT))
        else $error("store written outside shift or put");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted item not processed");
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_item.ready)
        else $error("input taken during clearing pass");
`endif
endmodule
